// ===== hw/rtl/hvr_pkg.sv =====
`timescale 1ns / 1ps

package hvr_pkg;

  localparam int HESSIAN_WIDTH_DEF = 24;

  // exponent arguments saturate just below 16.0 in q.16
  localparam logic [19:0] ARG_MAX = 20'hFFFFF;

  localparam logic [15:0] BLOB_SENS_RST   = 16'd128;
  localparam logic [15:0] STRUCT_SENS_RST = 16'd3840;
  localparam logic        DARK_RIDGES_RST = 1'b1;

  typedef enum logic [1:0] {
    CFG_BLOB_SENS   = 2'd0,
    CFG_STRUCT_SENS = 2'd1,
    CFG_DARK_RIDGES = 2'd2
  } cfg_idx_t;

  // round(2^32 * exp(-2^(i-16))) for argument bit i
  function automatic logic [31:0] exp_tab(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'd4294901760;
      5'd1:    val = 32'd4294836226;
      5'd2:    val = 32'd4294705160;
      5'd3:    val = 32'd4294443040;
      5'd4:    val = 32'd4293918848;
      5'd5:    val = 32'd4292870656;
      5'd6:    val = 32'd4290775039;
      5'd7:    val = 32'd4286586875;
      5'd8:    val = 32'd4278222805;
      5'd9:    val = 32'd4261543595;
      5'd10:   val = 32'd4228380000;
      5'd11:   val = 32'd4162825044;
      5'd12:   val = 32'd4034748382;
      5'd13:   val = 32'd3790295335;
      5'd14:   val = 32'd3344923893;
      5'd15:   val = 32'd2605029347;
      5'd16:   val = 32'd1580030169;
      5'd17:   val = 32'd581260615;
      5'd18:   val = 32'd78665070;
      5'd19:   val = 32'd1440801;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/hvr_sqrt_pipe.sv =====
`timescale 1ns / 1ps

// floor square root of a 64-bit radicand, one result bit per stage
module hvr_sqrt_pipe #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [63:0]   in_rad,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [31:0]   out_root,
  output logic [SW-1:0] out_side
);

  localparam int N = 32;

  logic [N-1:0]  vld_r;
  logic [33:0]   rem_r  [N];
  logic [31:0]   root_r [N];
  logic [63:0]   rad_r  [N];
  logic [SW-1:0] side_r [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic          vld_in;
    logic [33:0]   rem_in;
    logic [31:0]   root_in;
    logic [63:0]   rad_in;
    logic [SW-1:0] side_in;
    logic [35:0]   rem2;
    logic [35:0]   trial;
    logic          ge;
    logic [33:0]   rem_nxt;
    logic [31:0]   root_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      rem2     = {rem_in, rad_in[63:62]};
      trial    = {2'b00, root_in, 2'b01};
      ge       = (rem2 >= trial);
      rem_nxt  = ge ? 34'(rem2 - trial) : 34'(rem2);
      root_nxt = {root_in[30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= {rad_in[61:0], 2'b00};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== hw/rtl/hvr_div_pipe.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage; in_rem must be below in_div
module hvr_div_pipe #(
  parameter int DW = 32,
  parameter int QW = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] vld_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] div_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] div_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   rem2;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rem;
      assign low_in  = in_low;
      assign quo_in  = '0;
      assign div_in  = in_div;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign low_in  = low_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign div_in  = div_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      rem2    = {rem_in, low_in[QW-1]};
      ge      = (rem2 >= {1'b0, div_in});
      rem_nxt = ge ? DW'(rem2 - {1'b0, div_in}) : DW'(rem2);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        low_r[i]  <= {low_in[QW-2:0], 1'b0};
        quo_r[i]  <= {quo_in[QW-2:0], ge};
        div_r[i]  <= div_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// ===== hw/rtl/hvr_exp_pipe.sv =====
`timescale 1ns / 1ps

// exp(-x) for two q.16 arguments at once, one argument bit per stage, q1.32 out
module hvr_exp_pipe #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [19:0]   in_xa,
  input  logic [19:0]   in_xb,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [32:0]   out_ea,
  output logic [32:0]   out_eb,
  output logic [SW-1:0] out_side
);

  localparam int N = 20;

  logic [N-1:0]  vld_r;
  logic [19:0]   xa_r    [N];
  logic [19:0]   xb_r    [N];
  logic [N-1:0]  onea_r;
  logic [N-1:0]  oneb_r;
  logic [31:0]   acca_r  [N];
  logic [31:0]   accb_r  [N];
  logic [SW-1:0] side_r  [N];

  // accumulator equal to 1.0 is kept as a flag so the multiplier stays 32x32
  function automatic logic [32:0] exp_step(input logic one, input logic [31:0] acc,
                                           input logic take, input logic [31:0] tab);
    logic [63:0] prod;
    logic [32:0] res;
    prod = acc * tab + 64'h8000_0000;
    if (!take) begin
      res = {one, acc};
    end else if (one) begin
      res = {1'b0, tab};
    end else begin
      res = {1'b0, prod[63:32]};
    end
    return res;
  endfunction

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic          vld_in;
    logic [19:0]   xa_in;
    logic [19:0]   xb_in;
    logic          onea_in;
    logic          oneb_in;
    logic [31:0]   acca_in;
    logic [31:0]   accb_in;
    logic [SW-1:0] side_in;
    logic [32:0]   a_nxt;
    logic [32:0]   b_nxt;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign xa_in   = in_xa;
      assign xb_in   = in_xb;
      assign onea_in = 1'b1;
      assign oneb_in = 1'b1;
      assign acca_in = '0;
      assign accb_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign xa_in   = xa_r[i-1];
      assign xb_in   = xb_r[i-1];
      assign onea_in = onea_r[i-1];
      assign oneb_in = oneb_r[i-1];
      assign acca_in = acca_r[i-1];
      assign accb_in = accb_r[i-1];
      assign side_in = side_r[i-1];
    end

    always_comb begin
      a_nxt = exp_step(onea_in, acca_in, xa_in[i], hvr_pkg::exp_tab(5'(i)));
      b_nxt = exp_step(oneb_in, accb_in, xb_in[i], hvr_pkg::exp_tab(5'(i)));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xa_r[i]   <= xa_in;
        xb_r[i]   <= xb_in;
        onea_r[i] <= a_nxt[32];
        oneb_r[i] <= b_nxt[32];
        acca_r[i] <= a_nxt[31:0];
        accb_r[i] <= b_nxt[31:0];
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_ea    = onea_r[N-1] ? 33'h1_0000_0000 : {1'b0, acca_r[N-1]};
  assign out_eb    = oneb_r[N-1] ? 33'h1_0000_0000 : {1'b0, accb_r[N-1]};
  assign out_side  = side_r[N-1];

endmodule

// ===== hw/rtl/hessian_vesselness_response.sv =====
`timescale 1ns / 1ps
// throughput: one pixel per cycle; the whole pipeline holds while out_stall is high
// and a result is waiting, and in_stall is raised for that time
// depth is set by the 32-step square root, the 24-step dividers and the 20-step exp chains
// reset (synchronous, rst_n low) empties the pipeline and loads the register defaults

module hessian_vesselness_response #(
  parameter int HESSIAN_WIDTH = hvr_pkg::HESSIAN_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [HESSIAN_WIDTH-1:0] in_hess_xx,
  input  logic [HESSIAN_WIDTH-1:0] in_hess_xy,
  input  logic [HESSIAN_WIDTH-1:0] in_hess_yy,
  input  logic [15:0]              in_scale_sq,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              out_vesselness,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam int QW = HESSIAN_WIDTH + 16;

  logic        en;
  logic [15:0] blob_r;
  logic [15:0] struct_r;
  logic        dark_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blob_r   <= hvr_pkg::BLOB_SENS_RST;
      struct_r <= hvr_pkg::STRUCT_SENS_RST;
      dark_r   <= hvr_pkg::DARK_RIDGES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hvr_pkg::CFG_BLOB_SENS:   blob_r   <= cfg_data;
        hvr_pkg::CFG_STRUCT_SENS: struct_r <= cfg_data;
        hvr_pkg::CFG_DARK_RIDGES: dark_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage 1: scale the hessian entries
  logic signed [QW:0]   px_nxt, pm_nxt, py_nxt;
  logic                 v1_r;
  logic        [QW-1:0] qx_r, qm_r, qy_r;

  assign px_nxt = $signed(in_hess_xx) * $signed({1'b0, in_scale_sq});
  assign pm_nxt = $signed(in_hess_xy) * $signed({1'b0, in_scale_sq});
  assign py_nxt = $signed(in_hess_yy) * $signed({1'b0, in_scale_sq});

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= px_nxt[QW-1:0];
      qm_r <= pm_nxt[QW-1:0];
      qy_r <= py_nxt[QW-1:0];
    end
  end

  // stage 2: magnitudes and shift amount
  logic [QW-1:0] mx_nxt, mm_nxt, my_nxt, orv;
  logic [4:0]    k_nxt;
  logic          v2_r;
  logic [QW-1:0] mx_r, mm_r, my_r;
  logic          sx_r, sy_r;
  logic [4:0]    k_r;

  always_comb begin
    mx_nxt = qx_r[QW-1] ? (~qx_r + 1'b1) : qx_r;
    mm_nxt = qm_r[QW-1] ? (~qm_r + 1'b1) : qm_r;
    my_nxt = qy_r[QW-1] ? (~qy_r + 1'b1) : qy_r;
    orv    = mx_nxt | mm_nxt | my_nxt;
    k_nxt  = 5'd8;
    // raise the shift until every entry is below 2^30
    for (int j = 38; j < QW; j++) begin
      if (orv[j]) k_nxt = 5'(j - 29);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= mx_nxt;
      mm_r <= mm_nxt;
      my_r <= my_nxt;
      sx_r <= qx_r[QW-1];
      sy_r <= qy_r[QW-1];
      k_r  <= k_nxt;
    end
  end

  // stage 3: shift toward zero
  logic [29:0]        ma_nxt, mb_nxt, mc_nxt;
  logic               v3_r;
  logic [29:0]        ma_r, mb_r, mc_r;
  logic signed [30:0] a_r, c_r;
  logic               sh3_r;

  always_comb begin
    ma_nxt = 30'(mx_r >> k_r);
    mb_nxt = 30'(mm_r >> k_r);
    mc_nxt = 30'(my_r >> k_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      mc_r  <= mc_nxt;
      a_r   <= sx_r ? -$signed({1'b0, ma_nxt}) : $signed({1'b0, ma_nxt});
      c_r   <= sy_r ? -$signed({1'b0, mc_nxt}) : $signed({1'b0, mc_nxt});
      sh3_r <= (k_r > 5'd8);
    end
  end

  // stage 4: trace and squares
  logic signed [31:0] tr_nxt, dl_nxt;
  logic        [30:0] adl_nxt;
  logic               v4_r;
  logic signed [31:0] tr4_r;
  logic        [61:0] dsq_r;
  logic        [59:0] bsq_r, asq_r, csq_r;
  logic               sh4_r;

  always_comb begin
    tr_nxt  = 32'(a_r) + 32'(c_r);
    dl_nxt  = 32'(a_r) - 32'(c_r);
    adl_nxt = dl_nxt[31] ? 31'(-dl_nxt) : 31'(dl_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr4_r <= tr_nxt;
      dsq_r <= adl_nxt * adl_nxt;
      bsq_r <= mb_r * mb_r;
      asq_r <= ma_r * ma_r;
      csq_r <= mc_r * mc_r;
      sh4_r <= sh3_r;
    end
  end

  // stage 5: discriminant and structure energy
  logic               v5_r;
  logic        [63:0] disc_r, f5_r;
  logic signed [31:0] tr5_r;
  logic               sh5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      disc_r <= 64'(dsq_r) + {2'b00, bsq_r, 2'b00};
      f5_r   <= 64'(asq_r) + 64'(csq_r) + {3'b000, bsq_r, 1'b0};
      tr5_r  <= tr4_r;
      sh5_r  <= sh4_r;
    end
  end

  // square root
  logic        sq_valid;
  logic [31:0] sq_root;
  logic [96:0] sq_side;

  hvr_sqrt_pipe #(
    .SW(97)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v5_r),
    .in_rad   (disc_r),
    .in_side  ({sh5_r, tr5_r, f5_r}),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // stage 6: eigenvalues, zero and polarity check
  logic signed [33:0] l1_nxt, l2_nxt;
  logic               kill_nxt;
  logic               v6_r;
  logic        [33:0] u6_r, w6_r;
  logic        [63:0] f6_r;
  logic               kill6_r, sh6_r;

  always_comb begin
    l1_nxt   = 34'($signed(sq_side[95:64])) + $signed({2'b00, sq_root});
    l2_nxt   = 34'($signed(sq_side[95:64])) - $signed({2'b00, sq_root});
    kill_nxt = (l1_nxt == '0) || (dark_r ? l1_nxt[33] : !l1_nxt[33]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u6_r    <= l2_nxt[33] ? 34'(-l2_nxt) : 34'(l2_nxt);
      w6_r    <= l1_nxt[33] ? 34'(-l1_nxt) : 34'(l1_nxt);
      f6_r    <= sq_side[63:0];
      kill6_r <= kill_nxt;
      sh6_r   <= sq_side[96];
    end
  end

  // stage 7: divisors
  logic [15:0] b1_nxt, b2_nxt;
  logic        v7_r;
  logic [49:0] m7_r;
  logic [31:0] b2sq7_r;
  logic [33:0] u7_r;
  logic [63:0] f7_r;
  logic        kill7_r, sh7_r;

  assign b1_nxt = (blob_r == '0) ? 16'd1 : blob_r;
  assign b2_nxt = (struct_r == '0) ? 16'd1 : struct_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m7_r    <= w6_r * b1_nxt;
      b2sq7_r <= b2_nxt * b2_nxt;
      u7_r    <= u6_r;
      f7_r    <= f6_r;
      kill7_r <= kill6_r;
      sh7_r   <= sh6_r;
    end
  end

  // stage 8: saturation decisions
  logic        v8_r;
  logic [49:0] m8_r;
  logic [31:0] b2sq8_r;
  logic [33:0] u8_r;
  logic [63:0] f8_r;
  logic        kill8_r, satx8_r, saty8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m8_r    <= m7_r;
      b2sq8_r <= b2sq7_r;
      u8_r    <= u7_r;
      f8_r    <= f7_r;
      kill8_r <= kill7_r;
      satx8_r <= ({16'b0, u7_r} >= m7_r);
      saty8_r <= sh7_r || (f7_r >= {19'b0, b2sq7_r, 13'b0});
    end
  end

  // dividers
  logic        dvb_valid, dvs_valid;
  logic [23:0] dvb_quo, dvs_quo;
  logic [1:0]  dvb_side;
  logic        dvs_side;

  hvr_div_pipe #(
    .DW(50),
    .QW(24),
    .SW(2)
  ) u_div_blob (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v8_r),
    .in_rem   ({16'b0, u8_r}),
    .in_low   (24'b0),
    .in_div   (m8_r),
    .in_side  ({kill8_r, satx8_r}),
    .out_valid(dvb_valid),
    .out_quo  (dvb_quo),
    .out_side (dvb_side)
  );

  hvr_div_pipe #(
    .DW(32),
    .QW(24),
    .SW(1)
  ) u_div_struct (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v8_r),
    .in_rem   (32'(f8_r >> 17)),
    .in_low   ({f8_r[16:0], 7'b0}),
    .in_div   (b2sq8_r),
    .in_side  (saty8_r),
    .out_valid(dvs_valid),
    .out_quo  (dvs_quo),
    .out_side (dvs_side)
  );

  // stage 9: square of the eigenvalue ratio
  logic        v9_r;
  logic [47:0] tt9_r;
  logic [19:0] yq9_r;
  logic        satx9_r, kill9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tt9_r   <= dvb_quo * dvb_quo;
      yq9_r   <= dvs_side ? hvr_pkg::ARG_MAX : dvs_quo[19:0];
      satx9_r <= dvb_side[0];
      kill9_r <= dvb_side[1];
    end
  end

  // stage 10: blob argument
  logic [30:0] xr_nxt;
  logic        v10_r;
  logic [19:0] xq10_r, yq10_r;
  logic        kill10_r;

  assign xr_nxt = 31'(tt9_r >> 17);

  always_ff @(posedge clk) begin
    if (en) begin
      if (satx9_r || (xr_nxt > 31'(hvr_pkg::ARG_MAX))) begin
        xq10_r <= hvr_pkg::ARG_MAX;
      end else begin
        xq10_r <= xr_nxt[19:0];
      end
      yq10_r   <= yq9_r;
      kill10_r <= kill9_r;
    end
  end

  // exponentials
  logic        ex_valid;
  logic [32:0] ex_b, ex_s;
  logic        ex_kill;

  hvr_exp_pipe #(
    .SW(1)
  ) u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v10_r),
    .in_xa    (xq10_r),
    .in_xb    (yq10_r),
    .in_side  (kill10_r),
    .out_valid(ex_valid),
    .out_ea   (ex_b),
    .out_eb   (ex_s),
    .out_side (ex_kill)
  );

  // stage 11: product of the two terms
  logic [32:0] g_nxt;
  logic        v11_r;
  logic [49:0] prod11_r;
  logic        kill11_r;

  assign g_nxt = 33'h1_0000_0000 - ex_s;

  always_ff @(posedge clk) begin
    if (en) begin
      prod11_r <= ex_b[32:8] * g_nxt[32:8];
      kill11_r <= ex_kill;
    end
  end

  // stage 12: rounding, saturation, output register
  logic [50:0] rnd_nxt;
  logic [15:0] out_vess_r;

  assign rnd_nxt = 51'(prod11_r) + 51'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      if (kill11_r) begin
        out_vess_r <= '0;
      end else if (rnd_nxt[50:48] != '0) begin
        out_vess_r <= 16'hFFFF;
      end else begin
        out_vess_r <= rnd_nxt[47:32];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      v11_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= sq_valid;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      v9_r        <= dvb_valid && dvs_valid;
      v10_r       <= v9_r;
      v11_r       <= ex_valid;
      out_valid_r <= v11_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vesselness = out_vess_r;

endmodule

// ===== sim/hessian_vesselness_response_test.sv =====
`timescale 1ns / 1ps

module hessian_vesselness_response_test;

  localparam int HW = hvr_pkg::HESSIAN_WIDTH_DEF;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [HW-1:0] xx;
    logic [HW-1:0] xy;
    logic [HW-1:0] yy;
    logic [15:0]   scale;
    bit            known;
    logic [15:0]   resp;
  } pixel_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [HW-1:0] in_hess_xx;
  logic [HW-1:0] in_hess_xy;
  logic [HW-1:0] in_hess_yy;
  logic [15:0] in_scale_sq;
  logic out_valid;
  logic out_stall;
  logic [15:0] out_vesselness;
  logic cfg_we;
  hvr_pkg::cfg_idx_t cfg_index;
  logic [15:0] cfg_data;

  hessian_vesselness_response DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_hess_xx(in_hess_xx), .in_hess_xy(in_hess_xy), .in_hess_yy(in_hess_yy),
    .in_scale_sq(in_scale_sq),
    .out_valid(out_valid), .out_stall(out_stall), .out_vesselness(out_vesselness),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mirror of the block registers
  logic [15:0] blob_beta;
  logic [15:0] struct_beta;
  logic        dark_mode;

  logic [15:0] resp_queue[$];
  int errors;
  int pixels_sent;
  int responses_seen;
  int nonzero_seen;
  bit long_hold_req;
  bit quiet_sender;

  longint unsigned exp_rom[20] = '{
    64'd4294901760, 64'd4294836226, 64'd4294705160, 64'd4294443040, 64'd4293918848,
    64'd4292870656, 64'd4290775039, 64'd4286586875, 64'd4278222805, 64'd4261543595,
    64'd4228380000, 64'd4162825044, 64'd4034748382, 64'd3790295335, 64'd3344923893,
    64'd2605029347, 64'd1580030169, 64'd581260615,  64'd78665070,   64'd1440801
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout after %0d pixels, %0d responses", pixels_sent, responses_seen);
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint shift_toward_zero(longint v, int k);
    longint unsigned m;
    m = mag64(v) >> k;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exp(-x) for x in q.16, result in q1.32
  function automatic longint unsigned decay(logic [19:0] x);
    longint unsigned acc;
    acc = 64'd1 << 32;
    for (int i = 0; i < 20; i++)
      if (x[i]) acc = (acc * exp_rom[i] + (64'd1 << 31)) >> 32;
    return acc;
  endfunction

  function automatic logic [15:0] vesselness_of(logic signed [HW-1:0] hxx,
      logic signed [HW-1:0] hxy, logic signed [HW-1:0] hyy, logic [15:0] scale);
    longint qx, qm, qy, a, b, c, l1, l2;
    longint unsigned top, r, u, w, m, t, rem, big, f, bsq, b1, b2, bt, gt, v;
    logic [19:0] xq, yq;
    int k;
    qx = longint'(hxx) * longint'(scale);
    qm = longint'(hxy) * longint'(scale);
    qy = longint'(hyy) * longint'(scale);
    top = mag64(qx);
    if (mag64(qm) > top) top = mag64(qm);
    if (mag64(qy) > top) top = mag64(qy);
    k = 8;
    while ((top >> k) >= (64'd1 << 30)) k++;
    a = shift_toward_zero(qx, k);
    b = shift_toward_zero(qm, k);
    c = shift_toward_zero(qy, k);
    r = int_sqrt(mag64(a - c) * mag64(a - c) + 4 * (mag64(b) * mag64(b)));
    l1 = a + c + longint'(r);
    l2 = a + c - longint'(r);
    if (l1 == 0) return 16'd0;
    if (dark_mode ? (l1 < 0) : (l1 > 0)) return 16'd0;
    b1 = (blob_beta == 0) ? 1 : blob_beta;
    b2 = (struct_beta == 0) ? 1 : struct_beta;
    u = mag64(l2);
    w = mag64(l1);
    m = w * b1;
    if (u >= m) begin
      xq = hvr_pkg::ARG_MAX;
    end else begin
      rem = u;
      t = 0;
      for (int i = 0; i < 24; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= m) begin
          rem = rem - m;
          t = t | 1;
        end
      end
      big = (t * t) >> 17;
      xq = (big > hvr_pkg::ARG_MAX) ? hvr_pkg::ARG_MAX : big[19:0];
    end
    if (k > 8) begin
      yq = hvr_pkg::ARG_MAX;
    end else begin
      f = mag64(a) * mag64(a) + 2 * (mag64(b) * mag64(b)) + mag64(c) * mag64(c);
      bsq = b2 * b2;
      if (f >= (bsq << 13)) begin
        yq = hvr_pkg::ARG_MAX;
      end else begin
        big = (f << 7) / bsq;
        yq = (big > hvr_pkg::ARG_MAX) ? hvr_pkg::ARG_MAX : big[19:0];
      end
    end
    bt = decay(xq);
    gt = (64'd1 << 32) - decay(yq);
    v = ((bt >> 8) * (gt >> 8) + (64'd1 << 31)) >> 32;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int pause_len(bit allow_zero);
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 90);
    return $urandom_range(allow_zero ? 0 : 1, 3);
  endfunction

  task automatic write_reg(hvr_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hvr_pkg::CFG_BLOB_SENS:   blob_beta = val;
      hvr_pkg::CFG_STRUCT_SENS: struct_beta = val;
      hvr_pkg::CFG_DARK_RIDGES: dark_mode = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offers one pixel, returns after its transfer
  task automatic send_pixel(logic [HW-1:0] xx, logic [HW-1:0] xy, logic [HW-1:0] yy,
      logic [15:0] scale, bit known, logic [15:0] resp);
    int gap;
    in_valid <= 1'b1;
    in_hess_xx <= xx;
    in_hess_xy <= xy;
    in_hess_yy <= yy;
    in_scale_sq <= scale;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    resp_queue.insert(resp_queue.size(), known ? resp : vesselness_of(xx, xy, yy, scale));
    gap = quiet_sender ? 0 : pause_len(1'b1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (resp_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [HW-1:0] ranged(int lim);
    int v;
    v = $urandom_range(0, lim);
    return ($urandom_range(0, 1) != 0) ? HW'(-v) : HW'(v);
  endfunction

  task automatic random_pixel();
    logic [HW-1:0] xx, xy, yy;
    logic [15:0] scale;
    int sgn;
    case ($urandom_range(0, 3))
      0: begin
        xx = HW'($urandom());
        xy = HW'($urandom());
        yy = HW'($urandom());
        scale = 16'($urandom());
      end
      1: begin
        xx = ranged(1 << 14);
        xy = ranged(1 << 14);
        yy = ranged(1 << 14);
        scale = 16'($urandom_range(0, 1024));
      end
      default: begin
        // elongated structure with the polarity that survives
        sgn = dark_mode ? 1 : -1;
        xx = HW'(sgn * $urandom_range(256, 1 << 17));
        yy = ranged(1 << 11);
        xy = ranged(1 << 11);
        if ($urandom_range(0, 1) != 0) begin
          yy = xx;
          xx = ranged(1 << 11);
        end
        scale = 16'($urandom_range(16, 1024));
      end
    endcase
    send_pixel(xx, xy, yy, scale, 1'b0, 16'd0);
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      responses_seen++;
      if (out_vesselness != 0) nonzero_seen++;
      if (resp_queue.size() == 0) begin
        report_mismatch("unexpected vesselness", out_vesselness, 16'd0);
      end else begin
        if (out_vesselness !== resp_queue[0])
          report_mismatch("vesselness", out_vesselness, resp_queue[0]);
        void'(resp_queue.pop_front());
      end
    end
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
        repeat (1) @(posedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        n = $urandom_range(50, 300);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (pause_len(1'b0)) @(posedge clk);
        out_stall <= 1'b0;
        repeat (pause_len(1'b0)) @(posedge clk);
      end
    end
  end

  pixel_row_t directed[$];

  initial begin
    logic [15:0] phase_cfg[NUM_PHASES][3];
    errors = 0;
    pixels_sent = 0;
    responses_seen = 0;
    nonzero_seen = 0;
    long_hold_req = 1'b0;
    quiet_sender = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_hess_xx <= '0;
    in_hess_xy <= '0;
    in_hess_yy <= '0;
    in_scale_sq <= '0;
    cfg_we <= 1'b0;
    cfg_index <= hvr_pkg::CFG_BLOB_SENS;
    cfg_data <= '0;
    blob_beta = hvr_pkg::BLOB_SENS_RST;
    struct_beta = hvr_pkg::STRUCT_SENS_RST;
    dark_mode = hvr_pkg::DARK_RIDGES_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // known responses: zero l1 and wrong polarity give 0
    directed = '{
      '{24'h000000, 24'h000000, 24'h000000, 16'h0000, 1'b1, 16'd0},
      '{24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 1'b1, 16'd0},
      '{-24'sd4096, 24'h000000, -24'sd4096, 16'd256,  1'b1, 16'd0},
      '{24'd4096,   24'h000000, 24'h000000, 16'h0000, 1'b1, 16'd0},
      '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b0, 16'd0},
      '{24'h7FFFFF, 24'h000000, 24'h000000, 16'h0001, 1'b0, 16'd0},
      '{24'h000001, 24'h000000, 24'h000000, 16'h0001, 1'b0, 16'd0},
      '{24'd8192,   24'h000000, 24'h000000, 16'd256,  1'b0, 16'd0},
      '{24'd16384,  24'd50,     24'd100,    16'd256,  1'b0, 16'd0},
      '{24'd4096,   24'h000000, 24'd4096,   16'd256,  1'b0, 16'd0},
      '{24'h000000, 24'd4096,   24'h000000, 16'd256,  1'b0, 16'd0},
      '{24'hFFFFFF, 24'h000000, 24'h000000, 16'hFFFF, 1'b0, 16'd0},
      '{24'h7FFFFF, 24'h800000, 24'h000000, 16'd256,  1'b0, 16'd0},
      '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'hAAAA, 1'b0, 16'd0},
      '{24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555, 1'b0, 16'd0},
      '{24'd65536,  24'hFFFF00, 24'd300,    16'd512,  1'b0, 16'd0}
    };
    foreach (directed[i])
      send_pixel(directed[i].xx, directed[i].xy, directed[i].yy, directed[i].scale,
                 directed[i].known, directed[i].resp);
    drain();

    phase_cfg[0] = '{16'd128, 16'd3840, 16'd0};
    phase_cfg[1] = '{16'd1, 16'd1, 16'd1};
    phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'd0};
    phase_cfg[3] = '{16'd0, 16'd0, 16'd1};
    phase_cfg[4] = '{16'd256, 16'd64, 16'd1};
    for (int p = 5; p < NUM_PHASES; p++)
      phase_cfg[p] = '{16'($urandom_range(1, 2048)), 16'($urandom_range(1, 8192)),
                       16'($urandom_range(0, 1))};

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(hvr_pkg::CFG_BLOB_SENS, phase_cfg[p][0]);
      write_reg(hvr_pkg::CFG_STRUCT_SENS, phase_cfg[p][1]);
      write_reg(hvr_pkg::CFG_DARK_RIDGES, phase_cfg[p][2]);
      quiet_sender = (p == 4);
      if (p == 1) long_hold_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) random_pixel();
      drain();
    end

    $display("%0d pixels over %0d register settings, %0d responses (%0d nonzero)",
             pixels_sent, NUM_PHASES + 1, responses_seen, nonzero_seen);
    $display("covered zero and wrong-polarity ridges, beta extremes and a long output hold");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
